// ----- sv/tbt_pkg.sv -----
`default_nettype none

package tbt_pkg;

   // Table size and field widths.
   localparam int TBT_NUM_TASKS = 16;
   localparam int TASK_W        = 4;
   localparam int COUNT_W       = 5;
   localparam int TICK_W        = 48;
   localparam int NS_W          = 32;
   localparam int CONS_W        = 64;
   localparam int END_W         = TICK_W + 1;
   localparam int PT_W          = 13;
   localparam int MUL_A_W       = 32;
   localparam int MUL_B_W       = 27;
   localparam int MUL_W         = MUL_A_W + MUL_B_W;
   localparam int ID_EXT_W      = 9;

   // One tick is one million nanoseconds.
   localparam logic [MUL_B_W-1:0] NS_PER_TICK = MUL_B_W'(1000000);

   // A period is divided by one million as (period >> 6) / 15625. The quotient by
   // 15625 comes from a rounded-up reciprocal scaled by 2^40, which is exact for
   // every 26-bit dividend.
   localparam int DIV_PRE_SHIFT = 6;
   localparam int DIV_SHIFT     = 40;
   localparam logic [MUL_B_W-1:0] DIV_RECIP =
      MUL_B_W'(((64'd1 << DIV_SHIFT) + 64'd15624) / 64'd15625);

   // Reset values of the configuration registers.
   localparam logic [NS_W-1:0] MIN_PERIOD_RESET = NS_W'(1000000);
   localparam logic [NS_W-1:0] MAX_PERIOD_RESET = NS_W'(1000000000);

   // Configuration register indexes.
   localparam logic CSR_MIN_PERIOD = 1'b0;
   localparam logic CSR_MAX_PERIOD = 1'b1;

   typedef enum logic [1:0] {
      FUNC_SET     = 2'd0,
      FUNC_CLEAR   = 2'd1,
      FUNC_ACCOUNT = 2'd2,
      FUNC_SCAN    = 2'd3
   } func_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_OP_RD,
      ST_OP_SUM,
      ST_OP_WR,
      ST_SC_RD,
      ST_SC_DIV,
      ST_SC_END,
      ST_SC_CHK,
      ST_SC_FIN
   } state_type;

   typedef struct packed {
      logic [NS_W-1:0]   runtime;
      logic [NS_W-1:0]   period;
      logic [CONS_W-1:0] consumed;
      logic [TICK_W-1:0] start;
   } entry_type;

   typedef struct packed {
      logic               status;
      logic               may_run;
      logic               replenished_valid;
      logic [TASK_W-1:0]  replenished_task;
      logic [COUNT_W-1:0] replenished_count;
      logic               last;
   } rsp_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic req_ready;
      logic latch;
      logic rd_en;
      logic rd_scan;
      logic mul_en;
      logic mul_div;
      logic sum_en;
      logic end_en;
      logic commit_op;
      logic commit_repl;
      logic emit_final;
      logic idx_clr;
      logic idx_inc;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic req_valid;
      logic is_scan;
      logic hit;
      logic idx_last;
      logic rsp_free;
   } sts_type;

endpackage

`default_nettype wire

// ----- sv/tbt_req_if.sv -----
`default_nettype none

interface tbt_req_if;
   logic                            valid;
   logic                            ready;
   tbt_pkg::func_type               func;
   logic [tbt_pkg::TASK_W-1:0]      task_id;
   logic [tbt_pkg::NS_W-1:0]        runtime_ns;
   logic [tbt_pkg::NS_W-1:0]        period_ns;
   logic [tbt_pkg::NS_W-1:0]        elapsed_ticks;
   logic [tbt_pkg::TICK_W-1:0]      scan_tick;

   modport source (output valid, func, task_id, runtime_ns, period_ns, elapsed_ticks,
                   scan_tick, input ready);
   modport sink   (input valid, func, task_id, runtime_ns, period_ns, elapsed_ticks,
                   scan_tick, output ready);
endinterface

`default_nettype wire

// ----- sv/tbt_rsp_if.sv -----
`default_nettype none

interface tbt_rsp_if;
   logic                            valid;
   logic                            ready;
   logic                            status;
   logic                            may_run;
   logic                            replenished_valid;
   logic [tbt_pkg::TASK_W-1:0]      replenished_task;
   logic [tbt_pkg::COUNT_W-1:0]     replenished_count;
   logic                            last;

   modport source (output valid, status, may_run, replenished_valid, replenished_task,
                   replenished_count, last, input ready);
   modport sink   (input valid, status, may_run, replenished_valid, replenished_task,
                   replenished_count, last, output ready);
endinterface

`default_nettype wire

// ----- sv/tbt_ctrl.sv -----
`default_nettype none

module tbt_ctrl (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire tbt_pkg::sts_type sts,
   output tbt_pkg::cmd_type      cmd
);
   import tbt_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            cmd.req_ready = 1'b1;
            if (sts.req_valid) begin
               cmd.latch = 1'b1;
               if (sts.is_scan) begin
                  cmd.idx_clr = 1'b1;
                  state_in    = ST_SC_RD;
               end else begin
                  state_in = ST_OP_RD;
               end
            end
         end
         ST_OP_RD: begin
            cmd.rd_en  = 1'b1;
            cmd.mul_en = 1'b1;
            state_in   = ST_OP_SUM;
         end
         ST_OP_SUM: begin
            cmd.sum_en = 1'b1;
            state_in   = ST_OP_WR;
         end
         ST_OP_WR: begin
            if (sts.rsp_free) begin
               cmd.commit_op = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         ST_SC_RD: begin
            cmd.rd_en   = 1'b1;
            cmd.rd_scan = 1'b1;
            state_in    = ST_SC_DIV;
         end
         ST_SC_DIV: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_div = 1'b1;
            state_in    = ST_SC_END;
         end
         ST_SC_END: begin
            cmd.end_en = 1'b1;
            state_in   = ST_SC_CHK;
         end
         ST_SC_CHK: begin
            if (!sts.hit || sts.rsp_free) begin
               cmd.commit_repl = sts.hit;
               if (sts.idx_last) begin
                  state_in = ST_SC_FIN;
               end else begin
                  cmd.idx_inc = 1'b1;
                  state_in    = ST_SC_RD;
               end
            end
         end
         ST_SC_FIN: begin
            if (sts.rsp_free) begin
               cmd.emit_final = 1'b1;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // An entry that needs no replenish moves straight on to the next read.
   a_scan_skip: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SC_CHK && !sts.hit && !sts.idx_last) |=> state_ff == ST_SC_RD)
      else $error("scan did not advance past an idle entry");

endmodule

`default_nettype wire

// ----- sv/tbt_dp.sv -----
`default_nettype none

module tbt_dp #(
   parameter int NUM_TASKS = tbt_pkg::TBT_NUM_TASKS
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   tbt_req_if.sink                       req,
   tbt_rsp_if.source                     rsp,
   input  wire logic                     csr_we,
   input  wire logic                     csr_index,
   input  wire logic [tbt_pkg::NS_W-1:0] csr_wdata,
   input  wire tbt_pkg::cmd_type         cmd,
   output tbt_pkg::sts_type              sts
);
   import tbt_pkg::*;

   localparam int IDX_W = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;

   // Configuration.
   logic [NS_W-1:0] min_period_ff;
   logic [NS_W-1:0] max_period_ff;

   // Latched request fields.
   func_type          func_ff;
   logic [TASK_W-1:0] id_ff;
   logic [NS_W-1:0]   rt_ff;
   logic [NS_W-1:0]   pd_ff;
   logic [NS_W-1:0]   ticks_ff;
   logic [TICK_W-1:0] now_ff;

   // Task table.
   entry_type             mem [NUM_TASKS];
   logic [NUM_TASKS-1:0]  valid_ff;
   logic [NUM_TASKS-1:0]  valid_in;
   logic [NUM_TASKS-1:0]  thr_ff;
   logic [NUM_TASKS-1:0]  thr_in;
   entry_type             rd_ff;
   logic                  rd_vld_ff;
   logic                  rd_thr_ff;
   entry_type             entry;
   logic [IDX_W-1:0]      rd_addr;
   logic                  wr_en;
   logic [IDX_W-1:0]      wr_addr;
   entry_type             wr_data;

   // Arithmetic.
   logic [MUL_A_W-1:0]  mul_a;
   logic [MUL_B_W-1:0]  mul_b;
   logic [MUL_W-1:0]    mult_ff;
   logic [CONS_W:0]     sum_wide;
   logic [CONS_W-1:0]   sum_ff;
   logic [PT_W-1:0]     quot;
   logic [PT_W-1:0]     pt;
   logic [END_W-1:0]    end_ff;

   // Scan bookkeeping.
   logic [IDX_W-1:0]    idx_ff;
   logic [COUNT_W-1:0]  cnt_ff;
   logic [ID_EXT_W-1:0] id_ext;
   logic [ID_EXT_W-1:0] idx_ext;
   logic [IDX_W-1:0]    id_addr;
   logic                ok_id;
   logic                set_bad;
   logic                acct_live;
   logic                acct_hit;

   // Result register.
   rsp_type rsp_ff;
   rsp_type rsp_in;
   logic    rsp_vld_ff;
   logic    rsp_load;
   logic    rsp_free;

   assign req.ready = cmd.req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_period_ff <= MIN_PERIOD_RESET;
         max_period_ff <= MAX_PERIOD_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_MIN_PERIOD: min_period_ff <= csr_wdata;
            CSR_MAX_PERIOD: max_period_ff <= csr_wdata;
            default:        min_period_ff <= min_period_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         func_ff  <= req.func;
         id_ff    <= req.task_id;
         rt_ff    <= req.runtime_ns;
         pd_ff    <= req.period_ns;
         ticks_ff <= req.elapsed_ticks;
         now_ff   <= req.scan_tick;
      end
   end

   assign id_ext  = ID_EXT_W'(id_ff);
   assign idx_ext = ID_EXT_W'(idx_ff);
   assign id_addr = id_ext[IDX_W-1:0];
   assign ok_id   = id_ext < ID_EXT_W'(NUM_TASKS);
   assign rd_addr = cmd.rd_scan ? idx_ff : id_addr;

   // Table read with registered data; an entry never written reads as zero.
   always_ff @(posedge clock) begin
      if (cmd.rd_en) begin
         rd_ff     <= mem[rd_addr];
         rd_vld_ff <= valid_ff[rd_addr];
         rd_thr_ff <= thr_ff[rd_addr];
      end
   end

   assign entry = rd_vld_ff ? rd_ff : '0;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         thr_ff   <= '0;
      end else begin
         valid_ff <= valid_in;
         thr_ff   <= thr_in;
      end
   end

   // One shared multiplier: ticks times one million, or period times reciprocal.
   assign mul_a = cmd.mul_div ? MUL_A_W'(entry.period >> DIV_PRE_SHIFT) : ticks_ff;
   assign mul_b = cmd.mul_div ? DIV_RECIP : NS_PER_TICK;

   always_ff @(posedge clock) begin
      if (cmd.mul_en) begin
         mult_ff <= MUL_W'(mul_a) * MUL_W'(mul_b);
      end
   end

   assign sum_wide = (CONS_W + 1)'(entry.consumed) + (CONS_W + 1)'(mult_ff);

   always_ff @(posedge clock) begin
      if (cmd.sum_en) begin
         sum_ff <= sum_wide[CONS_W] ? '1 : sum_wide[CONS_W-1:0];
      end
   end

   assign quot = mult_ff[DIV_SHIFT +: PT_W];
   assign pt   = (quot == '0) ? PT_W'(1) : quot;

   always_ff @(posedge clock) begin
      if (cmd.end_en) begin
         end_ff <= END_W'(entry.start) + END_W'(pt);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.idx_clr) begin
         idx_ff <= '0;
         cnt_ff <= '0;
      end else begin
         if (cmd.idx_inc) begin
            idx_ff <= idx_ff + IDX_W'(1);
         end
         if (cmd.commit_repl) begin
            cnt_ff <= cnt_ff + COUNT_W'(1);
         end
      end
   end

   assign set_bad = !ok_id ||
                    ((rt_ff != '0) &&
                     ((pd_ff < min_period_ff) || (pd_ff > max_period_ff) || (rt_ff > pd_ff)));
   assign acct_live = ok_id && (entry.runtime != '0);
   assign acct_hit  = sum_ff >= CONS_W'(entry.runtime);

   // Table updates and result formation.
   always_comb begin
      wr_en    = 1'b0;
      wr_addr  = id_addr;
      wr_data  = entry;
      valid_in = valid_ff;
      thr_in   = thr_ff;
      rsp_load = 1'b0;
      rsp_in   = '0;
      if (cmd.commit_op) begin
         rsp_load    = 1'b1;
         rsp_in.last = 1'b1;
         unique case (func_ff)
            FUNC_SET: begin
               rsp_in.status = set_bad;
               if (!set_bad) begin
                  wr_en             = 1'b1;
                  wr_data           = '0;
                  wr_data.runtime   = rt_ff;
                  wr_data.period    = pd_ff;
                  valid_in[id_addr] = 1'b1;
                  thr_in[id_addr]   = 1'b0;
               end
            end
            FUNC_CLEAR: begin
               if (ok_id) begin
                  valid_in[id_addr] = 1'b0;
                  thr_in[id_addr]   = 1'b0;
               end
            end
            FUNC_ACCOUNT: begin
               rsp_in.may_run = 1'b1;
               if (acct_live) begin
                  wr_en             = 1'b1;
                  wr_data.consumed  = sum_ff;
                  valid_in[id_addr] = 1'b1;
                  if (acct_hit) begin
                     thr_in[id_addr] = 1'b1;
                     rsp_in.may_run  = 1'b0;
                  end
               end
            end
            FUNC_SCAN: begin
               rsp_in.last = 1'b1;
            end
            default: begin
               rsp_in.last = 1'b1;
            end
         endcase
      end else if (cmd.commit_repl) begin
         wr_en                    = 1'b1;
         wr_addr                  = idx_ff;
         wr_data.consumed         = '0;
         wr_data.start            = now_ff;
         valid_in[idx_ff]         = 1'b1;
         thr_in[idx_ff]           = 1'b0;
         rsp_load                 = 1'b1;
         rsp_in.replenished_valid = 1'b1;
         rsp_in.replenished_task  = idx_ext[TASK_W-1:0];
      end else if (cmd.emit_final) begin
         rsp_load                 = 1'b1;
         rsp_in.replenished_count = cnt_ff;
         rsp_in.last              = 1'b1;
      end
   end

   assign rsp_free = !rsp_vld_ff || rsp.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_vld_ff <= 1'b1;
      end else if (rsp.ready) begin
         rsp_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp.valid             = rsp_vld_ff;
   assign rsp.status            = rsp_ff.status;
   assign rsp.may_run           = rsp_ff.may_run;
   assign rsp.replenished_valid = rsp_ff.replenished_valid;
   assign rsp.replenished_task  = rsp_ff.replenished_task;
   assign rsp.replenished_count = rsp_ff.replenished_count;
   assign rsp.last              = rsp_ff.last;

   assign sts.req_valid = req.valid;
   assign sts.is_scan   = req.func == FUNC_SCAN;
   assign sts.hit       = rd_vld_ff && rd_thr_ff && (entry.runtime != '0) &&
                          (END_W'(now_ff) >= end_ff);
   assign sts.idx_last  = idx_ff == IDX_W'(NUM_TASKS - 1);
   assign sts.rsp_free  = rsp_free;

   a_rsp_reset: assert property (@(posedge clock) reset |=> !rsp_vld_ff)
      else $error("result register not empty after reset");

   a_rsp_slot: assert property (@(posedge clock) disable iff (reset)
      (cmd.commit_op || cmd.commit_repl || cmd.emit_final) |-> rsp_free)
      else $error("result loaded over an untaken beat");

   a_repl_beat: assert property (@(posedge clock) disable iff (reset)
      cmd.commit_repl |=> rsp_vld_ff && rsp_ff.replenished_valid && !rsp_ff.last)
      else $error("replenish beat malformed");

endmodule

`default_nettype wire

// ----- sv/task_runtime_budget_throttle.sv -----
// Per-task CPU runtime budget table with period-based throttling.
// Requests arrive as beats on req_chan (valid/ready); each carries an operation:
// set budget, clear budget, account ticks, or replenish scan. Results leave as
// beats on rsp_chan; the final beat of every request has last set.
// Set, clear and account give one beat each. A request is taken in the idle state
// and passes through the read, sum and write states; its beat is loaded into the
// output register in the write state once it is free, and the block then returns
// to idle. The table read runs alongside the multiply of the ticks by one million;
// the 64-bit saturating add and the write-back each have a state of their own.
// The scan walks every table entry in turn (read, divide the period by one million
// through the shared multiplier, form the period end, compare and write back),
// emits one beat per replenished task in ascending id order and then a count beat.
// The output register separates the two channels, so a new request is accepted
// while an earlier result beat still waits. A stalled receiver holds the block
// only when a further beat is due. Reset empties the table at once through
// per-entry valid bits and restores the period limits; no clearing pass runs.
// The user writes the period limits on the csr_ port only while the block is idle;
// the block itself does not enforce this.
`default_nettype none

module task_runtime_budget_throttle #(
   parameter int NUM_TASKS = tbt_pkg::TBT_NUM_TASKS
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   tbt_req_if.sink                       req_chan,
   tbt_rsp_if.source                     rsp_chan,
   input  wire logic                     csr_we,
   input  wire logic                     csr_index,
   input  wire logic [tbt_pkg::NS_W-1:0] csr_wdata
);
   import tbt_pkg::*;

   // Command and status between the sequencer and the datapath.
   cmd_type cmd;
   sts_type sts;

   // The controller sequences each request through the table and arithmetic.
   tbt_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .sts   (sts),
      .cmd   (cmd)
   );

   // The datapath owns the table, the configuration and the result register.
   tbt_dp #(
      .NUM_TASKS (NUM_TASKS)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req       (req_chan),
      .rsp       (rsp_chan),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .sts       (sts)
   );

endmodule

`default_nettype wire

// ----- dv/task_runtime_budget_throttle_check.sv -----
`default_nettype none

module task_runtime_budget_throttle_check (
   input  wire logic                     clock,
   input  wire logic                     reset,
   tbt_req_if                            req_mon,
   tbt_rsp_if                            rsp_mon,
   input  wire logic                     csr_we,
   input  wire logic                     csr_index,
   input  wire logic [tbt_pkg::NS_W-1:0] csr_wdata,
   output int                            mismatches,
   output int                            beats_due
);
   timeunit 1ns;
   timeprecision 1ps;
   import tbt_pkg::*;

   logic [NS_W-1:0]   lim_min;
   logic [NS_W-1:0]   lim_max;
   logic [NS_W-1:0]   run_budget   [TBT_NUM_TASKS];
   logic [NS_W-1:0]   period_len   [TBT_NUM_TASKS];
   logic [CONS_W-1:0] used_ns      [TBT_NUM_TASKS];
   logic [TICK_W-1:0] window_start [TBT_NUM_TASKS];
   logic              held         [TBT_NUM_TASKS];
   rsp_type           budget_beats [$];

   task automatic wipe_entry(input int idx);
      run_budget[idx]   = '0;
      period_len[idx]   = '0;
      used_ns[idx]      = '0;
      window_start[idx] = '0;
      held[idx]         = 1'b0;
   endtask

   // Works out every beat that one request causes and updates the budget table.
   task automatic predict_budget(input func_type op, input logic [TASK_W-1:0] id,
                                 input logic [NS_W-1:0] rt, input logic [NS_W-1:0] pd,
                                 input logic [NS_W-1:0] ticks,
                                 input logic [TICK_W-1:0] at_tick);
      rsp_type            beat;
      logic [CONS_W:0]    total;
      logic [CONS_W-1:0]  charge;
      logic [NS_W-1:0]    whole_ticks;
      logic [TICK_W:0]    period_end;
      logic [COUNT_W-1:0] freed;
      int                 i;
      beat  = '0;
      freed = '0;
      case (op)
         FUNC_SET: begin
            if (rt != '0 && (pd < lim_min || pd > lim_max || rt > pd)) begin
               beat.status = 1'b1;
            end else begin
               wipe_entry(id);
               run_budget[id] = rt;
               period_len[id] = pd;
            end
         end
         FUNC_CLEAR: begin
            wipe_entry(id);
         end
         FUNC_ACCOUNT: begin
            beat.may_run = 1'b1;
            if (run_budget[id] != '0) begin
               charge = CONS_W'(ticks) * CONS_W'(NS_PER_TICK);
               total  = {1'b0, used_ns[id]} + {1'b0, charge};
               used_ns[id] = total[CONS_W] ? '1 : total[CONS_W-1:0];
               if (used_ns[id] >= CONS_W'(run_budget[id])) begin
                  held[id]     = 1'b1;
                  beat.may_run = 1'b0;
               end
            end
         end
         default: begin
            for (i = 0; i < TBT_NUM_TASKS; i++) begin
               if (run_budget[i] != '0 && held[i]) begin
                  whole_ticks = period_len[i] / NS_W'(NS_PER_TICK);
                  if (whole_ticks == '0) begin
                     whole_ticks = NS_W'(1);
                  end
                  period_end = {1'b0, window_start[i]} + END_W'(whole_ticks);
                  if ({1'b0, at_tick} >= period_end) begin
                     used_ns[i]      = '0;
                     window_start[i] = at_tick;
                     held[i]         = 1'b0;
                     beat                   = '0;
                     beat.replenished_valid = 1'b1;
                     beat.replenished_task  = TASK_W'(i);
                     budget_beats.push_back(beat);
                     freed++;
                  end
               end
            end
            beat = '0;
            beat.replenished_count = freed;
         end
      endcase
      beat.last = 1'b1;
      budget_beats.push_back(beat);
   endtask

   task automatic match_beat(input rsp_type seen);
      rsp_type want;
      if (budget_beats.size() == 0) begin
         $error("result beat arrived with no expectation waiting");
         mismatches++;
         return;
      end
      want = budget_beats.pop_front();
      if (seen.status !== want.status) begin
         $error("status: expected %0d, got %0d", want.status, seen.status);
         mismatches++;
      end
      if (seen.may_run !== want.may_run) begin
         $error("may_run: expected %0d, got %0d", want.may_run, seen.may_run);
         mismatches++;
      end
      if (seen.replenished_valid !== want.replenished_valid) begin
         $error("replenished_valid: expected %0d, got %0d", want.replenished_valid,
                seen.replenished_valid);
         mismatches++;
      end
      if (seen.replenished_task !== want.replenished_task) begin
         $error("replenished_task: expected %0d, got %0d", want.replenished_task,
                seen.replenished_task);
         mismatches++;
      end
      if (seen.replenished_count !== want.replenished_count) begin
         $error("replenished_count: expected %0d, got %0d", want.replenished_count,
                seen.replenished_count);
         mismatches++;
      end
      if (seen.last !== want.last) begin
         $error("last: expected %0d, got %0d", want.last, seen.last);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin
      int i;
      if (reset) begin
         lim_min = MIN_PERIOD_RESET;
         lim_max = MAX_PERIOD_RESET;
         for (i = 0; i < TBT_NUM_TASKS; i++) begin
            wipe_entry(i);
         end
         budget_beats.delete();
         mismatches = 0;
      end else begin
         if (csr_we) begin
            if (csr_index == CSR_MIN_PERIOD) begin
               lim_min = csr_wdata;
            end else begin
               lim_max = csr_wdata;
            end
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            match_beat({rsp_mon.status, rsp_mon.may_run, rsp_mon.replenished_valid,
                        rsp_mon.replenished_task, rsp_mon.replenished_count,
                        rsp_mon.last});
         end
         if (req_mon.valid && req_mon.ready) begin
            predict_budget(req_mon.func, req_mon.task_id, req_mon.runtime_ns,
                           req_mon.period_ns, req_mon.elapsed_ticks, req_mon.scan_tick);
         end
      end
      beats_due <= budget_beats.size();
   end

endmodule

`default_nettype wire

// ----- dv/task_runtime_budget_throttle_test.sv -----
`default_nettype none

module task_runtime_budget_throttle_test;
   timeunit 1ns;
   timeprecision 1ps;
   import tbt_pkg::*;

   // Longest run of cycles in which no beat moves on either channel. A full scan
   // with nothing to replenish moves no beat before its count beat, well within this limit.
   localparam int QUIET_LIMIT = 2000;
   localparam int PHASE_OPS   = 20;

   logic            clock = 1'b0;
   logic            reset = 1'b1;
   logic            csr_we;
   logic            csr_index;
   logic [NS_W-1:0] csr_wdata;

   tbt_req_if req_chan ();
   tbt_rsp_if rsp_chan ();

   int mismatches;
   int beats_due;
   int quiet_cycles = 0;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int ops_sent = 0;

   // The stimulus keeps its own copy of the period limits so that most random
   // budgets land inside them, and its own notion of the current tick.
   logic [NS_W-1:0]   lim_lo = MIN_PERIOD_RESET;
   logic [NS_W-1:0]   lim_hi = MAX_PERIOD_RESET;
   logic [TICK_W-1:0] tick_now = '0;

   task_runtime_budget_throttle dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   task_runtime_budget_throttle_check budget_check (
      .clock      (clock),
      .reset      (reset),
      .req_mon    (req_chan),
      .rsp_mon    (rsp_chan),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .mismatches (mismatches),
      .beats_due  (beats_due)
   );

   always #10 clock = ~clock;

   // The receiver decides afresh at every falling edge whether it will take a beat.
   always @(negedge clock) begin
      rsp_chan.ready = ($urandom_range(99) >= recv_idle_pct);
   end

   // Watchdog: a stuck handshake on either side ends the run as a failure.
   always @(posedge clock) begin
      if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("FAIL task_runtime_budget_throttle");
         $finish;
      end
   end

   function automatic logic [TICK_W-1:0] rand_tick();
      return {16'($urandom), 32'($urandom)};
   endfunction

   // Presents one request beat from a falling edge and holds it until the block
   // takes it. The valid line is left high on return, so a following request
   // goes out back to back unless the sender chooses to idle first.
   task automatic push_op(input func_type op, input logic [TASK_W-1:0] id,
                          input logic [NS_W-1:0] rt, input logic [NS_W-1:0] pd,
                          input logic [NS_W-1:0] ticks, input logic [TICK_W-1:0] at_tick);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_chan.valid = 1'b0;
         @(negedge clock);
      end
      req_chan.valid         = 1'b1;
      req_chan.func          = op;
      req_chan.task_id       = id;
      req_chan.runtime_ns    = rt;
      req_chan.period_ns     = pd;
      req_chan.elapsed_ticks = ticks;
      req_chan.scan_tick     = at_tick;
      @(posedge clock);
      while (!req_chan.ready) begin
         @(posedge clock);
      end
      ops_sent++;
   endtask

   // Fields an operation does not use are filled at random, which spreads
   // activity over every bit of every field.
   task automatic set_op(input logic [TASK_W-1:0] id, input logic [NS_W-1:0] rt,
                         input logic [NS_W-1:0] pd);
      push_op(FUNC_SET, id, rt, pd, $urandom, rand_tick());
   endtask

   task automatic clear_op(input logic [TASK_W-1:0] id);
      push_op(FUNC_CLEAR, id, $urandom, $urandom, $urandom, rand_tick());
   endtask

   task automatic charge_op(input logic [TASK_W-1:0] id, input logic [NS_W-1:0] ticks);
      push_op(FUNC_ACCOUNT, id, $urandom, $urandom, ticks, rand_tick());
   endtask

   task automatic scan_op(input logic [TICK_W-1:0] at_tick);
      push_op(FUNC_SCAN, TASK_W'($urandom), $urandom, $urandom, $urandom, at_tick);
   endtask

   // Drops valid at the next falling edge, then holds off until every expected
   // beat has arrived and the block has had time to settle back to idle.
   task automatic drain(input int settle);
      @(negedge clock);
      req_chan.valid = 1'b0;
      do begin
         @(posedge clock);
      end while (beats_due != 0);
      repeat (settle) @(posedge clock);
   endtask

   // Limits are only ever changed with the block idle; both registers are
   // written each time.
   task automatic write_limits(input logic [NS_W-1:0] lo, input logic [NS_W-1:0] hi);
      drain(6);
      @(negedge clock);
      csr_we    = 1'b1;
      csr_index = CSR_MIN_PERIOD;
      csr_wdata = lo;
      @(negedge clock);
      csr_index = CSR_MAX_PERIOD;
      csr_wdata = hi;
      @(negedge clock);
      csr_we = 1'b0;
      lim_lo = lo;
      lim_hi = hi;
   endtask

   // One random operation. Most budgets are legal under the present limits and
   // small enough that a few accounts throttle the task, so that the scans
   // regularly find something to replenish; the rest is noise.
   task automatic random_op();
      logic [NS_W-1:0] span;
      logic [NS_W-1:0] pd;
      logic [NS_W-1:0] rt;
      int              roll;
      roll = $urandom_range(99);
      if (roll < 25) begin
         span = lim_hi - lim_lo;
         if (lim_hi < lim_lo) begin
            span = '0;
         end else if (span > 20000000) begin
            span = 20000000;
         end
         pd = lim_lo + $urandom_range(span);
         rt = (pd == '0 || $urandom_range(4) == 0) ? '0 : $urandom_range(pd, 1);
         if ($urandom_range(7) == 0) begin
            rt = $urandom;
            pd = $urandom;
         end
         set_op(TASK_W'($urandom), rt, pd);
      end else if (roll < 30) begin
         clear_op(TASK_W'($urandom));
      end else if (roll < 65) begin
         charge_op(TASK_W'($urandom),
                   ($urandom_range(9) == 0) ? $urandom : $urandom_range(3));
      end else if (roll < 92) begin
         if ($urandom_range(9) == 0) begin
            scan_op(rand_tick());
         end else begin
            tick_now = tick_now + $urandom_range(12);
            scan_op(tick_now);
         end
      end else begin
         // The sender waits here for every outstanding beat before going on.
         drain(0);
      end
   endtask

   initial begin
      int phase;
      int i;
      int phase_start;
      req_chan.valid         = 1'b0;
      req_chan.func          = FUNC_SET;
      req_chan.task_id       = '0;
      req_chan.runtime_ns    = '0;
      req_chan.period_ns     = '0;
      req_chan.elapsed_ticks = '0;
      req_chan.scan_tick     = '0;
      rsp_chan.ready         = 1'b0;
      csr_we                 = 1'b0;
      csr_index              = CSR_MIN_PERIOD;
      csr_wdata              = '0;

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      send_idle_pct = 26;
      recv_idle_pct = 57;

      // Directed part, first under the reset limits. A scan of the empty table
      // must return only the count beat.
      scan_op('0);
      // An unlimited budget is always accepted and never throttles.
      set_op(0, '0, '0);
      charge_op(0, '1);
      // Periods on and just beyond either limit, and a runtime above its period.
      set_op(1, 1000000, 1000000);
      set_op(2, 1, 999999);
      set_op(3, 1000000000, 1000000000);
      set_op(4, 1, 1000000001);
      set_op(5, 1500001, 1500000);
      // Task 1 stays runnable on zero ticks, throttles on one and keeps
      // accumulating while throttled.
      charge_op(1, 0);
      charge_op(1, 1);
      charge_op(1, 3);
      charge_op(3, 999);
      charge_op(3, 1);
      // Task 1 has a one-tick period and task 3 a thousand-tick period.
      scan_op(0);
      scan_op(1);
      scan_op(1000);
      clear_op(3);
      charge_op(3, 5);

      // Widest limits: a period below one tick is treated as one tick, and the
      // largest runtime and period are legal.
      write_limits('0, '1);
      set_op(6, 1, 1);
      set_op(7, '1, '1);
      charge_op(6, 1);
      charge_op(7, '1);
      charge_op(1, 1);
      scan_op(48'hFFFF_FFFF_FFFE);
      charge_op(6, 2);
      charge_op(7, 1);
      charge_op(7, 4295);
      // The end of task 7's period lies beyond the tick range; it must not wrap
      // round and replenish early, whereas task 6 is due.
      scan_op(48'hFFFF_FFFF_FFFF);

      // Inverted limits reject every limited budget but still take an
      // unlimited one.
      write_limits('1, '0);
      set_op(8, 1, 32'h8000_0000);
      set_op(8, '0, 5);

      // Random part in three phases, each with its own idling and limits.
      for (phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               write_limits(1000000, 20000000);
            end
            1: begin
               send_idle_pct = 57;
               recv_idle_pct = 26;
               write_limits('0, 8000000);
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
               write_limits(2000000, '1);
               // Throttle the whole table, then replenish it in a single scan of
               // sixteen id beats and a count of sixteen.
               for (i = 0; i < TBT_NUM_TASKS; i++) begin
                  set_op(TASK_W'(i), 1, lim_lo);
                  charge_op(TASK_W'(i), 1);
               end
               tick_now = tick_now + 2;
               scan_op(tick_now);
            end
         endcase
         phase_start = ops_sent;
         while (ops_sent - phase_start < PHASE_OPS) begin
            random_op();
         end
      end

      // Wait for the last beats, then long enough for a full scan to show up.
      drain(80);
      if (mismatches == 0 && beats_due == 0) begin
         $display("PASS task_runtime_budget_throttle");
      end else begin
         $display("FAIL task_runtime_budget_throttle");
      end
      $finish;
   end

endmodule

`default_nettype wire
